[design/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg: shared types for the line rasterizer
// Command and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic capture;  // latch start point and raw deltas
    logic setup;    // derive deltas, directions and error term
    logic advance;  // emit current pixel and move one step
  } cmd_t;

  typedef struct packed {
    logic last;     // current pixel is the final endpoint
  } status_t;

endpackage

[design/lr_ctrl.sv]
// ----------------------------------------------------------------------------
// lr_ctrl: line rasterizer controller
// Sequences load setup and pixel steps, drives busy and the result strobe.
// ----------------------------------------------------------------------------
module lr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             op,
  input  lr_pkg::status_t  status,
  output logic             busy,
  output logic             out_valid,
  output lr_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DRAW
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   valid_r, valid_nxt;
  logic   accept;

  assign accept = start & ~busy_r;

  always_comb begin
    state_nxt   = state_r;
    busy_nxt    = 1'b0;
    valid_nxt   = 1'b0;
    cmd.capture = 1'b0;
    cmd.setup   = 1'b0;
    cmd.advance = 1'b0;
    unique case (state_r)
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_DRAW;
      end
      ST_IDLE, ST_DRAW: begin
        if (accept && (op == lr_pkg::OP_LOAD)) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SETUP;
          busy_nxt    = 1'b1;
        end else if (accept && (state_r == ST_DRAW)) begin
          cmd.advance = 1'b1;
          valid_nxt   = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

[design/lr_datapath.sv]
// ----------------------------------------------------------------------------
// lr_datapath: line rasterizer datapath
// Delta setup, Bresenham error update, coordinate counters and output word.
// ----------------------------------------------------------------------------
module lr_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  lr_pkg::cmd_t                 cmd,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output lr_pkg::status_t              status,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_last
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  logic signed [C:0]    dx_r, dy_r;
  logic signed [C-1:0]  cur_x_r, cur_y_r;
  logic signed [EW-1:0] err_r;
  logic [C:0]           steps_r;
  logic [C-1:0]         major_r, minor_r;
  logic                 xneg_r, yneg_r, ymaj_r;
  logic signed [C-1:0]  px_r, py_r;
  logic                 plast_r;

  // setup terms
  logic [C:0]           adx_full, ady_full;
  logic [C-1:0]         adx, ady, major_nxt, minor_nxt;
  logic                 ymaj_nxt;
  logic signed [EW-1:0] err_init;

  // step terms
  logic signed [EW-1:0] two_minor, two_diff, err_step;
  logic                 minor_move, last;
  logic signed [C-1:0]  x_inc, y_inc;

  assign adx_full  = dx_r[C] ? (-dx_r) : dx_r;
  assign ady_full  = dy_r[C] ? (-dy_r) : dy_r;
  assign adx       = adx_full[C-1:0];
  assign ady       = ady_full[C-1:0];
  assign ymaj_nxt  = ady > adx;
  assign major_nxt = ymaj_nxt ? ady : adx;
  assign minor_nxt = ymaj_nxt ? adx : ady;
  assign err_init  = $signed({2'b00, minor_nxt, 1'b0}) - $signed({3'b000, major_nxt});

  assign two_minor  = $signed({2'b00, minor_r, 1'b0});
  assign two_diff   = two_minor - $signed({2'b00, major_r, 1'b0});
  assign minor_move = ~err_r[EW-1] & (err_r != '0);
  assign err_step   = err_r + (minor_move ? two_diff : two_minor);
  assign last       = (steps_r[C:1] == '0);
  assign x_inc      = xneg_r ? '1 : C'(1);
  assign y_inc      = yneg_r ? '1 : C'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r    <= {in_end_x[C-1], in_end_x} - {in_start_x[C-1], in_start_x};
      dy_r    <= {in_end_y[C-1], in_end_y} - {in_start_y[C-1], in_start_y};
      cur_x_r <= in_start_x;
      cur_y_r <= in_start_y;
    end else if (cmd.setup) begin
      xneg_r  <= dx_r[C];
      yneg_r  <= dy_r[C];
      ymaj_r  <= ymaj_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      err_r   <= err_init;
      steps_r <= {1'b0, major_nxt} + (C+1)'(1);
    end else if (cmd.advance) begin
      px_r    <= cur_x_r;
      py_r    <= cur_y_r;
      plast_r <= last;
      err_r   <= err_step;
      steps_r <= last ? '0 : steps_r - (C+1)'(1);
      if (ymaj_r) begin
        cur_y_r <= cur_y_r + y_inc;
        if (minor_move) begin
          cur_x_r <= cur_x_r + x_inc;
        end
      end else begin
        cur_x_r <= cur_x_r + x_inc;
        if (minor_move) begin
          cur_y_r <= cur_y_r + y_inc;
        end
      end
    end
  end

  assign status.last = last;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_last    = plast_r;

endmodule

[design/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line generator, all eight octants
// Load two endpoints, then each step emits one pixel until the last one.
// ----------------------------------------------------------------------------
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  input    | start & !busy      | in_op, in_start_x/y, in_end_x/y
//  result   | out_valid (1 cyc)  | out_pixel_x, out_pixel_y, out_last
//
// a load latches the deltas, then busy is high for one setup cycle that
// forms directions, major axis and the error term.
// a step's pixel appears on the next cycle for one cycle; steps may follow
// back to back, one pixel per clock.
// reset (synchronous, active low) drops any active line. the receiver
// cannot stall, so the result register never holds a word back.
module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_last
);

  lr_pkg::cmd_t    cmd;
  lr_pkg::status_t status;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_op),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .status      (status),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_last    (out_last)
  );

endmodule

[tb/line_rasterizer_test.sv]
// ----------------------------------------------------------------------------
// line_rasterizer_test: self-checking bench for the Bresenham line generator
// Drives loads and steps with random gaps, predicts every pixel with a
// behavioral line tracer and compares each emitted word field by field.
// ----------------------------------------------------------------------------
module line_rasterizer_test;

  localparam int CB = 12;
  localparam int WORD_TARGET = 1550;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } pixel_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  logic   in_op;
  coord_t in_start_x;
  coord_t in_start_y;
  coord_t in_end_x;
  coord_t in_end_y;
  logic   out_valid;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last;

  line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .out_valid   (out_valid),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_last    (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // line tracer state
  logic   trace_active;
  coord_t trace_x;
  coord_t trace_y;
  int     trace_err;
  int     trace_remaining;
  int     trace_major;
  int     trace_minor;
  bit     trace_x_neg;
  bit     trace_y_neg;
  bit     trace_y_major;

  pixel_t pixel_queue[$];
  int     errors;
  int     live_words;
  bit     no_idle;

  task automatic trace_word(input lr_pkg::op_t op, input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey);
    int     dx;
    int     dy;
    int     adx;
    int     ady;
    bit     move;
    pixel_t px;
    if (op == lr_pkg::OP_LOAD) begin
      dx = ex - sx;
      dy = ey - sy;
      trace_x_neg = dx < 0;
      trace_y_neg = dy < 0;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      trace_y_major = ady > adx;
      trace_major = trace_y_major ? ady : adx;
      trace_minor = trace_y_major ? adx : ady;
      trace_err = 2 * trace_minor - trace_major;
      trace_remaining = trace_major + 1;
      trace_x = sx;
      trace_y = sy;
      trace_active = 1'b1;
      live_words++;
    end else if (trace_active) begin
      px.x = trace_x;
      px.y = trace_y;
      px.last = trace_remaining <= 1;
      pixel_queue.push_back(px);
      live_words++;
      move = trace_err > 0;
      if (move) trace_err += 2 * (trace_minor - trace_major);
      else trace_err += 2 * trace_minor;
      // major axis always moves, minor only on a positive error
      if (trace_y_major || move) trace_y = trace_y_neg ? trace_y - 1'b1 : trace_y + 1'b1;
      if (!trace_y_major || move) trace_x = trace_x_neg ? trace_x - 1'b1 : trace_x + 1'b1;
      if (trace_remaining <= 1) begin
        trace_remaining = 0;
        trace_active = 1'b0;
      end else begin
        trace_remaining--;
      end
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t unexpected pixel word x=%0d y=%0d last=%0b", $time,
                   out_pixel_x, out_pixel_y, out_last);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (out_pixel_x !== want.x) begin
            $display("%0t pixel_x expected %0d got %0d", $time, want.x, out_pixel_x);
            errors++;
          end
          if (out_pixel_y !== want.y) begin
            $display("%0t pixel_y expected %0d got %0d", $time, want.y, out_pixel_y);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t last expected %0b got %0b", $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (start && !busy)
        trace_word(lr_pkg::op_t'(in_op), in_start_x, in_start_y, in_end_x, in_end_y);
    end
  end

  // hold start high until the word is taken; start stays high on return
  task automatic send_word(input lr_pkg::op_t op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    @(negedge clk);
    start <= 1'b1;
    in_op <= op;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_step();
    send_word(lr_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sender holds off until every pending pixel is out
  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t clamp_coord(input int v);
    if (v > 2047) return coord_t'(2047);
    if (v < -2048) return coord_t'(-2048);
    return coord_t'(v);
  endfunction

  function automatic int line_length(input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey);
    int dx;
    int dy;
    dx = ex - sx;
    dy = ey - sy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  task automatic test_steps_without_line();
    send_step();
    idle_gap(1);
    send_step();
  endtask

  task automatic test_single_point();
    send_word(lr_pkg::OP_LOAD, 12'sd5, -12'sd7, 12'sd5, -12'sd7);
    send_step();
    send_step();  // line already finished
    drain_pixels();
  endtask

  task automatic test_extreme_reload();
    send_word(lr_pkg::OP_LOAD, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
    repeat (3) send_step();
    // new load drops the line in flight
    send_word(lr_pkg::OP_LOAD, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
    repeat (2) send_step();
    drain_pixels();
  endtask

  task automatic test_steep_and_diagonal();
    send_word(lr_pkg::OP_LOAD, 12'sd3, 12'sd3, 12'sd1, -12'sd1);
    repeat (5) send_step();
    idle_gap(2);
    // equal deltas keep x as the major axis
    send_word(lr_pkg::OP_LOAD, 12'sd0, 12'sd0, -12'sd2, -12'sd2);
    repeat (3) send_step();
    drain_pixels();
  endtask

  task automatic test_random_lines();
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     n;
    int     r;
    int     next_drain;
    next_drain = live_words + 150;
    while (live_words < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      no_idle = $urandom_range(0, 4) == 0;
      if (r < 85) begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        if ($urandom_range(0, 6) != 0) begin
          ex = clamp_coord(int'(sx) + int'($urandom_range(0, 32)) - 16);
          ey = clamp_coord(int'(sy) + int'($urandom_range(0, 32)) - 16);
        end else begin
          ex = coord_t'($urandom);
          ey = coord_t'($urandom);
        end
        n = line_length(sx, sy, ex, ey);
        if (n > 40) n = $urandom_range(1, 12);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
        else n = n + $urandom_range(0, 2);
        idle_gap(gap_len());
        send_word(lr_pkg::OP_LOAD, sx, sy, ex, ey);
        repeat (n) begin
          idle_gap(gap_len());
          send_step();
        end
      end else begin
        idle_gap(gap_len());
        send_word($urandom_range(0, 1) ? lr_pkg::OP_STEP : lr_pkg::OP_LOAD,
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
      end
      if (live_words >= next_drain) begin
        drain_pixels();
        next_drain = live_words + 150;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors = 0;
    live_words = 0;
    no_idle = 1'b0;
    trace_active = 1'b0;
    trace_x = '0;
    trace_y = '0;
    trace_err = 0;
    trace_remaining = 0;
    trace_major = 0;
    trace_minor = 0;
    trace_x_neg = 1'b0;
    trace_y_neg = 1'b0;
    trace_y_major = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = lr_pkg::OP_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_steps_without_line();
    test_single_point();
    test_extreme_reload();
    test_steep_and_diagonal();
    test_random_lines();

    drain_pixels();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("line_rasterizer regression: pass");
    end else begin
      $display("line_rasterizer regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("line_rasterizer regression: fail");
    $finish;
  end

endmodule
